@@ design/slrg_pkg.sv @@
package slrg_pkg;

	// Lehmer minimal standard generator
	localparam logic [30:0] LEH_MOD  = 31'h7FFF_FFFF;
	localparam logic [14:0] LEH_MULT = 15'd16807;
	localparam int          MULT_W   = 15;
	localparam int          PROD_W   = 31 + MULT_W;

	// defaults and warm-up length
	localparam int          TABLE_DEPTH_DEF = 32;
	localparam int          WARM_DISCARD    = 8;
	localparam logic [30:0] SEED_RESET      = 31'd123456789;

	// reciprocal for the slot divide: q0 = (x * RECIP) >> RECIP_SHIFT
	localparam int RECIP_SHIFT = 38;
	localparam int RECIP_W     = 14;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WARM_MUL,
		ST_WARM_FOLD,
		ST_DRAW_MUL,
		ST_DRAW_SLOT,
		ST_DRAW_SWAP,
		ST_DRAW_OUT
	} state_t;

	// x * 16807 mod (2^31 - 1), folded from the 46-bit product
	function automatic logic [30:0] lehmer_fold(input logic [PROD_W-1:0] p);
		logic [31:0] s;
		s = {1'b0, p[30:0]} + {{(32-(PROD_W-31)){1'b0}}, p[PROD_W-1:31]};
		if (s >= {1'b0, LEH_MOD})
			s = s - {1'b0, LEH_MOD};
		return s[30:0];
	endfunction

	// floor(p / (2^31 - 1)) for a 47-bit product below 2^31 * 2^16
	function automatic logic [15:0] scale_fold(input logic [46:0] p);
		logic [31:0] r;
		logic [15:0] q;
		r = {1'b0, p[30:0]} + {16'd0, p[46:31]};
		q = p[46:31];
		if (r >= {1'b0, LEH_MOD})
			q = q + 16'd1;
		return q;
	endfunction

endpackage

@@ design/slrg_ram.sv @@
module slrg_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

@@ design/shuffled_lehmer_random_generator_top.sv @@
// Shuffled Lehmer random generator (minimal standard step behind a shuffle table).
//
// Channels:
//   cfg      : seed write. Always ready. A transfer loads the 31-bit seed and
//              schedules a warm-up on the next draw. Write only while idle.
//   s_axis   : one transfer per draw; tdata carries the scale bound n.
//   m_axis   : one transfer per draw; raw shuffled value and floor(raw*n/(2^31-1)).
//
// Sequence: after the input transfer a plain draw passes the slot, swap and
// output states; the result is loaded into the output register in the output
// state once that register is free. The steps are the generator update
// (multiply, then fold modulo 2^31-1) and the registered read of the shuffle RAM.
// A draw with a pending warm-up first runs the warm-up steps, each a multiply
// state and then a fold state, before the draw multiply state.
//
// Reset: seed returns to 123456789 and a warm-up is pending; the shuffle RAM
// is not cleared, the warm-up fills it before any read.
// Stall: the output register holds one result; a new item is still taken
// while it waits, and that draw parks in its last stage until the sink takes
// the previous result.
module shuffled_lehmer_random_generator_top #(
	parameter int TABLE_DEPTH = slrg_pkg::TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// seed register write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [30:0] cfg_data,      // seed_value
	// draw requests
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [15:0] scale_bound
	// results
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata   // [30:0] raw_value, [46:31] scaled_value, [47] zero
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int KW = $clog2(TABLE_DEPTH + 1);
	localparam int PW = $clog2(TABLE_DEPTH + slrg_pkg::WARM_DISCARD);
	localparam longint LEH_DIV = 64'd1 + (64'(slrg_pkg::LEH_MOD) - 64'd1) / TABLE_DEPTH;
	localparam longint RECIP = (64'd1 << slrg_pkg::RECIP_SHIFT) / LEH_DIV;
	localparam int RP_W = 31 + slrg_pkg::RECIP_W;

	slrg_pkg::state_t state_q, state_nx;

	logic [30:0] seed_q;
	logic        needs_warm_q;
	logic [30:0] gen_q;
	logic [30:0] last_q;
	logic [15:0] bound_q;
	logic [PW-1:0] pos_q;
	logic [AW-1:0] slot_q;

	logic [slrg_pkg::PROD_W-1:0] prod_q;   // gen_q * 16807
	logic [RP_W-1:0]             recip_q;  // last_q * RECIP
	logic [46:0]                 sprod_q;  // table value * bound

	logic        out_valid_q;
	logic [30:0] out_raw_q;
	logic [15:0] out_scaled_q;

	logic        in_xfer;
	logic        out_free;
	logic [30:0] step_val;
	logic [30:0] seed_fix;

	// slot = last_q / LEH_DIV: reciprocal estimate, then one threshold correction
	logic [31:0]   thr_tab [TABLE_DEPTH+1];
	logic [AW-1:0] q0;
	logic [KW-1:0] k_idx;
	logic          ge;
	logic [KW-1:0] slot_sum;
	logic [AW-1:0] slot;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [30:0]   ram_wdata;
	logic [30:0]   ram_rdata;

	assign cfg_ready     = 1'b1;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign step_val      = slrg_pkg::lehmer_fold(prod_q);
	assign seed_fix      = (seed_q == '0 || seed_q == slrg_pkg::LEH_MOD) ? 31'd1 : seed_q;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_scaled_q, out_raw_q};

	always_comb begin
		for (int k = 0; k <= TABLE_DEPTH; k++)
			thr_tab[k] = 32'(longint'(k) * LEH_DIV);
	end

	assign q0       = recip_q[slrg_pkg::RECIP_SHIFT +: AW];
	assign k_idx    = KW'(q0) + KW'(1);
	assign ge       = {1'b0, last_q} >= thr_tab[k_idx];
	assign slot_sum = KW'(q0) + KW'(ge);
	assign slot     = (slot_sum > KW'(TABLE_DEPTH - 1)) ? AW'(TABLE_DEPTH - 1) : AW'(slot_sum);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			slrg_pkg::ST_IDLE: begin
				if (in_xfer)
					state_nx = needs_warm_q ? slrg_pkg::ST_WARM_MUL : slrg_pkg::ST_DRAW_SLOT;
			end
			slrg_pkg::ST_WARM_MUL:  state_nx = slrg_pkg::ST_WARM_FOLD;
			slrg_pkg::ST_WARM_FOLD: begin
				state_nx = (pos_q == '0) ? slrg_pkg::ST_DRAW_MUL : slrg_pkg::ST_WARM_MUL;
			end
			slrg_pkg::ST_DRAW_MUL:  state_nx = slrg_pkg::ST_DRAW_SLOT;
			slrg_pkg::ST_DRAW_SLOT: state_nx = slrg_pkg::ST_DRAW_SWAP;
			slrg_pkg::ST_DRAW_SWAP: state_nx = slrg_pkg::ST_DRAW_OUT;
			slrg_pkg::ST_DRAW_OUT: begin
				if (out_free)
					state_nx = slrg_pkg::ST_IDLE;
			end
			default: state_nx = slrg_pkg::ST_IDLE;
		endcase
	end

	// control outputs: handshake and RAM write port
	always_comb begin
		s_axis_tready = 1'b0;
		ram_we        = 1'b0;
		ram_waddr     = slot_q;
		ram_wdata     = gen_q;
		case (state_q)
			slrg_pkg::ST_IDLE: s_axis_tready = 1'b1;
			slrg_pkg::ST_WARM_FOLD: begin
				ram_we    = pos_q < PW'(TABLE_DEPTH);
				ram_waddr = pos_q[AW-1:0];
				ram_wdata = step_val;
			end
			slrg_pkg::ST_DRAW_SWAP: ram_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= slrg_pkg::ST_IDLE;
			seed_q       <= slrg_pkg::SEED_RESET;
			needs_warm_q <= 1'b1;
			gen_q        <= '0;
			last_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_valid && cfg_ready) begin
				seed_q       <= cfg_data;
				needs_warm_q <= 1'b1;
			end else if (state_q == slrg_pkg::ST_IDLE && in_xfer) begin
				needs_warm_q <= 1'b0;
			end
			if (state_q == slrg_pkg::ST_DRAW_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				slrg_pkg::ST_IDLE: begin
					if (in_xfer && needs_warm_q)
						gen_q <= seed_fix;
				end
				slrg_pkg::ST_WARM_FOLD: begin
					gen_q <= step_val;
					if (pos_q == '0)
						last_q <= step_val;  // slot 0 holds the final warm-up value
				end
				slrg_pkg::ST_DRAW_SLOT: gen_q <= step_val;
				slrg_pkg::ST_DRAW_SWAP: last_q <= ram_rdata;
				default: ;
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		prod_q  <= slrg_pkg::PROD_W'(gen_q) * slrg_pkg::PROD_W'(slrg_pkg::LEH_MULT);
		recip_q <= RP_W'(last_q) * RP_W'(RECIP);
		if (in_xfer) begin
			bound_q <= s_axis_tdata;
			pos_q   <= PW'(TABLE_DEPTH + slrg_pkg::WARM_DISCARD - 1);
		end else if (state_q == slrg_pkg::ST_WARM_FOLD && pos_q != '0) begin
			pos_q <= pos_q - PW'(1);
		end
		if (state_q == slrg_pkg::ST_DRAW_SLOT)
			slot_q <= slot;
		if (state_q == slrg_pkg::ST_DRAW_SWAP)
			sprod_q <= 47'(ram_rdata) * 47'(bound_q);
		if (state_q == slrg_pkg::ST_DRAW_OUT && out_free) begin
			out_raw_q    <= last_q;
			out_scaled_q <= slrg_pkg::scale_fold(sprod_q);
		end
	end

	slrg_ram #(
		.WIDTH(31),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(slot),
		.rdata(ram_rdata)
	);

	// a draw with a pending warm-up must start the warm-up loop
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && needs_warm_q) |=> state_q == slrg_pkg::ST_WARM_MUL)
		else $error("warm-up skipped");

	// the generator is never at zero or the modulus when a draw reaches the swap state
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == slrg_pkg::ST_DRAW_SWAP) |-> (gen_q != '0 && gen_q != slrg_pkg::LEH_MOD))
		else $error("generator state out of range");

	// the shuffle slot stays inside the table
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == slrg_pkg::ST_DRAW_SLOT) |-> slot_sum < KW'(TABLE_DEPTH))
		else $error("slot out of range");

	// a result appears only at the end of a draw
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == slrg_pkg::ST_DRAW_OUT)
		else $error("unexpected result");

	// RAM writes happen only in the warm-up fold or the table swap
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == slrg_pkg::ST_WARM_FOLD || state_q == slrg_pkg::ST_DRAW_SWAP))
		else $error("stray table write");

endmodule

@@ sim/slrg_checker.sv @@
module slrg_checker #(
	parameter int TABLE_DEPTH = slrg_pkg::TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [30:0] cfg_data,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] scale_bound
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [47:0] m_axis_tdata,   // [30:0] raw_value, [46:31] scaled_value
	output int          mismatch_count,
	output int          draws_in_flight
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint unsigned MOD      = 64'(slrg_pkg::LEH_MOD);
	localparam longint unsigned SLOT_DIV = 1 + (MOD - 1) / TABLE_DEPTH;

	typedef struct packed {
		logic [30:0] raw;
		logic [15:0] scaled;
	} draw_t;

	// shadow of the generator
	logic [30:0] seed_q;
	logic [30:0] gen_q;
	logic [30:0] last_q;
	logic [30:0] shuffle_q [TABLE_DEPTH];
	bit          warm_pending;
	draw_t       expected_draws [$];

	function automatic logic [30:0] minstd_next(input logic [30:0] x);
		longint unsigned p;
		p = 64'(x) * 64'(slrg_pkg::LEH_MULT);
		return 31'(p % MOD);
	endfunction

	// seed load, discard steps, then fill from the top slot down
	task automatic refill_shuffle();
		logic [30:0] x;
		int          pos;
		x = seed_q;
		if (x == 31'd0 || x == slrg_pkg::LEH_MOD)
			x = 31'd1;
		for (pos = TABLE_DEPTH + slrg_pkg::WARM_DISCARD - 1; pos >= 0; pos--) begin
			x = minstd_next(x);
			if (pos < TABLE_DEPTH)
				shuffle_q[pos] = x;
		end
		gen_q        = x;
		last_q       = shuffle_q[0];
		warm_pending = 1'b0;
	endtask

	task automatic draw_once(input logic [15:0] bound, output draw_t d);
		longint unsigned slot;
		if (warm_pending)
			refill_shuffle();
		gen_q = minstd_next(gen_q);
		slot  = 64'(last_q) / SLOT_DIV;
		if (slot >= TABLE_DEPTH)
			slot = TABLE_DEPTH - 1;
		last_q          = shuffle_q[slot];
		shuffle_q[slot] = gen_q;
		d.raw    = last_q;
		d.scaled = 16'((64'(last_q) * 64'(bound)) / MOD);
	endtask

	always @(posedge clk or negedge arst_n) begin
		draw_t want;
		draw_t got;
		if (!arst_n) begin
			seed_q       = slrg_pkg::SEED_RESET;
			gen_q        = '0;
			last_q       = '0;
			warm_pending = 1'b1;
			expected_draws.delete();
			mismatch_count  = 0;
			draws_in_flight = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				seed_q       = cfg_data;
				warm_pending = 1'b1;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				draw_once(s_axis_tdata, want);
				expected_draws = {expected_draws, want};
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.raw    = m_axis_tdata[30:0];
				got.scaled = m_axis_tdata[46:31];
				if (expected_draws.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: unexpected result raw=%0d scaled=%0d",
							$realtime, got.raw, got.scaled);
				end else begin
					want = expected_draws.pop_front();
					if (got.raw != want.raw || got.scaled != want.scaled) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("%0t: mismatch raw exp=%0d got=%0d, scaled exp=%0d got=%0d",
								$realtime, want.raw, got.raw, want.scaled, got.scaled);
					end
				end
			end
			draws_in_flight = expected_draws.size();
		end
	end

endmodule

@@ sim/testbench.sv @@
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// run shape
	localparam int ITEMS_PER_PHASE = 230;
	localparam int RANDOM_PHASES   = 8;
	localparam int HOLD_PHASE      = 5;     // a no-idle phase, so the sender keeps pushing
	localparam int HOLD_CYCLES     = 300;
	localparam int STALL_LIMIT     = 4000;  // covers warm-up plus the long sink hold
	localparam int SETTLE_CYCLES   = 10;

	typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [30:0] cfg_data      = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;

	int          mismatch_count;
	int          draws_in_flight;
	idle_mode_t  idle_mode     = IDLE_NONE;
	int          phase_no      = 0;
	int          quiet_cycles  = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	shuffled_lehmer_random_generator_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),       // seed_value
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // [15:0] scale_bound
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)    // [30:0] raw_value, [46:31] scaled_value, [47] zero
	);

	// scoreboard sits on all three channels
	slrg_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.mismatch_count  (mismatch_count),
		.draws_in_flight (draws_in_flight)
	);

	// percent of cycles each side sits out, per idle mode
	function automatic int sender_idle_pct();
		case (idle_mode)
			IDLE_SENDER: return 79;
			IDLE_BOTH:   return 20;
			default:     return 0;
		endcase
	endfunction

	function automatic int receiver_stall_pct();
		case (idle_mode)
			IDLE_RECEIVER: return 79;
			IDLE_BOTH:     return 20;
			default:       return 0;
		endcase
	endfunction

	// bounds: tiny, near full scale, single bits, anything
	function automatic logic [15:0] random_bound();
		case ($urandom_range(0, 5))
			0:       return 16'($urandom_range(0, 15));
			1:       return 16'(65535 - $urandom_range(0, 15));
			2:       return 16'(1) << $urandom_range(0, 15);
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// sink side: random stalls by mode, plus one long hold when the hold phase opens
	always @(negedge clk) begin
		static int phase_seen = 0;
		static int hold_left  = 0;
		if (phase_no != phase_seen && phase_no == HOLD_PHASE)
			hold_left = HOLD_CYCLES;
		phase_seen = phase_no;
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct());
		end
	end

	// watchdog: too long with no transfer on any channel means a hang
	always @(posedge clk) begin
		if ((cfg_valid && cfg_ready) || (s_axis_tvalid && s_axis_tready) ||
		    (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("** shuffled_lehmer_random_generator_top: FAILED **");
			$finish;
		end
	end

	// one draw request; valid stays up across back-to-back transfers
	task automatic send_draw(input logic [15:0] bound);
		@(negedge clk);
		while ($urandom_range(0, 99) < sender_idle_pct()) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= bound;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// stop offering and let every outstanding result come out
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		wait (draws_in_flight == 0);
	endtask

	// seed writes only happen once drained
	task automatic write_seed(input logic [30:0] seed);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= seed;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [30:0] seed;
		int          p;
		int          n;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// --- directed ---
		// reset seed first, with bound extremes and alternating bit patterns
		send_draw(16'd0);
		send_draw(16'hFFFF);
		send_draw(16'd1);
		send_draw(16'd2);
		send_draw(16'h8000);
		send_draw(16'h5555);
		send_draw(16'hAAAA);
		drain();

		// zero seed is loaded as one
		write_seed(31'd0);
		send_draw(16'hFFFF);
		send_draw(16'd3);
		drain();

		// seed equal to the modulus is also loaded as one
		write_seed(slrg_pkg::LEH_MOD);
		send_draw(16'hFFFF);
		send_draw(16'd1);
		drain();

		write_seed(31'd1);
		send_draw(16'd100);
		send_draw(16'hFFFF);
		drain();

		write_seed(slrg_pkg::LEH_MOD - 31'd1);
		send_draw(16'hFFFF);
		send_draw(16'd7);
		drain();

		// two writes with no draw between; the second one wins
		write_seed(31'h2AAA_AAAA);
		write_seed(31'h5555_5555);
		send_draw(16'hFFFF);
		drain();

		// --- random phases, cycling through the idle modes ---
		for (p = 1; p <= RANDOM_PHASES; p++) begin
			phase_no  = p;
			idle_mode = idle_mode_t'((p - 1) % 4);
			// most phases reseed, some keep running the old sequence
			case ($urandom_range(0, 5))
				0: ;
				1: begin
					case ($urandom_range(0, 3))
						0:       seed = 31'd0;
						1:       seed = slrg_pkg::LEH_MOD;
						2:       seed = 31'd1;
						default: seed = slrg_pkg::LEH_MOD - 31'd1;
					endcase
					write_seed(seed);
				end
				default: write_seed(31'($urandom()));
			endcase
			for (n = 0; n < ITEMS_PER_PHASE; n++)
				send_draw(random_bound());
			// sender waits here until every result is back
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && draws_in_flight == 0)
			$display("** shuffled_lehmer_random_generator_top: PASSED **");
		else
			$display("** shuffled_lehmer_random_generator_top: FAILED **");
		$finish;
	end

endmodule
